FILE: design/deq_pkg.sv
package deq_pkg;

   localparam int DEPTH    = 16;
   localparam int WORD_W   = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_FIND       = 3'd4,
      MODE_CLEAR      = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef logic [WORD_W-1:0] word_type;

   // per-cell load controls
   typedef struct packed {
      logic load;
      logic from_prev;
      logic from_next;
   } cell_ctl_type;

   // operation outcome handed to the response stage
   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data;
      logic              is_find;
      logic [DEPTH-1:0]  match;
      logic [CNT_W-1:0]  count;
   } stage_type;

   function automatic logic [DATA_W-1:0] word_to_out(input word_type w);
      logic signed [WORD_W-1:0] sw;
      sw = w;
      return DATA_W'(sw);
   endfunction

endpackage

FILE: design/deq_cell.sv
module deq_cell (
   input  logic                    clock,
   input  deq_pkg::cell_ctl_type   ctl,
   input  deq_pkg::word_type       value_in,
   input  deq_pkg::word_type       prev_word,
   input  deq_pkg::word_type       next_word,
   input  logic                    live,
   output deq_pkg::word_type       word,
   output logic                    match
);
   import deq_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         word_in = value_in;
      end else if (ctl.from_prev) begin
         word_in = prev_word;
      end else if (ctl.from_next) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = live && (word_ff == value_in);

endmodule

FILE: design/deq_resp.sv
module deq_resp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           stage_valid,
   input  deq_pkg::stage_type             stage,
   output logic                           stage_take,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [deq_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_data_out,
   output logic signed [deq_pkg::POS_W-1:0]  rsp_position,
   output logic [deq_pkg::COUNT_W-1:0]    rsp_count,
   output logic                           rsp_empty_res
);
   import deq_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [COUNT_W-1:0]  count_ff;
   logic                empty_ff;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_take = stage_valid && out_free;

   // first match from the front wins; no match gives all ones, a non-find gives zero
   always_comb begin
      pos_in = '1;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (stage.match[i]) begin
            pos_in = POS_W'(i);
         end
      end
      if (!stage.is_find) begin
         pos_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         status_ff <= stage.status;
         data_ff   <= stage.data;
         pos_ff    <= pos_in;
         count_ff  <= COUNT_W'(stage.count);
         empty_ff  <= (stage.count == '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_data_out  = data_ff;
   assign rsp_position  = pos_ff;
   assign rsp_count     = count_ff;
   assign rsp_empty_res = empty_ff;

endmodule

FILE: design/double_ended_queue_with_search.sv
// Double-ended queue of signed words with a parallel search over a row of cells.
// A result is valid once its word's outcome has passed the stage register (cell
// update and compare) and then the output register (first-match encode).
// Throughput: one word per cycle while the result side keeps taking words.
// Reset clears the fill count and all valid flags; cell contents are left as is
// and are never read before being written.
module double_ended_queue_with_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [deq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_data_out,
   output logic signed [deq_pkg::POS_W-1:0]  rsp_position,
   output logic [deq_pkg::COUNT_W-1:0]       rsp_count,
   output logic                              rsp_empty_res
);
   import deq_pkg::*;

   // occupancy and stage handshake
   logic [CNT_W-1:0] count_ff, count_in;
   logic             stage_valid_ff, stage_valid_in;
   stage_type        stage_ff, stage_in;
   logic             stage_take;
   logic             req_fire;

   // decoded operation
   logic     full, empty;
   logic     push_front_ok, push_back_ok, pop_front_ok, pop_back_ok;
   logic     do_find, do_clear;
   word_type value_w;

   // cell row wiring
   cell_ctl_type     ctl   [DEPTH];
   word_type         words [DEPTH];
   word_type         prev_w[DEPTH];
   word_type         next_w[DEPTH];
   logic [DEPTH-1:0] live;
   logic [DEPTH-1:0] last;
   logic [DEPTH-1:0] match;
   word_type         tail_word;

   assign req_fire = req_valid && req_ready;
   assign value_w  = WORD_W'(req_value);

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // only an accepted word moves the cells
   assign push_front_ok = req_fire && (req_mode == MODE_PUSH_FRONT) && !full;
   assign push_back_ok  = req_fire && (req_mode == MODE_PUSH_BACK)  && !full;
   assign pop_front_ok  = req_fire && (req_mode == MODE_POP_FRONT)  && !empty;
   assign pop_back_ok   = req_fire && (req_mode == MODE_POP_BACK)   && !empty;
   assign do_find       = (req_mode == MODE_FIND);
   assign do_clear      = (req_mode == MODE_CLEAR);

   // Row of cells: front at index 0. Push front shifts every cell toward the
   // back, pop front shifts toward the front, push back loads the cell at the
   // fill count only, and pop back touches no cell.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign live[i] = (CNT_W'(i) < count_ff);
      assign last[i] = (CNT_W'(i + 1) == count_ff);

      assign ctl[i].load      = (push_front_ok && (i == 0)) ||
                                (push_back_ok && (count_ff == CNT_W'(i)));
      assign ctl[i].from_prev = push_front_ok && (i != 0);
      assign ctl[i].from_next = pop_front_ok && (i != DEPTH - 1);

      if (i == 0) begin : g_head
         assign prev_w[i] = value_w;
      end else begin : g_body
         assign prev_w[i] = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign next_w[i] = words[i];
      end else begin : g_mid
         assign next_w[i] = words[i+1];
      end

      deq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .value_in  (value_w),
         .prev_word (prev_w[i]),
         .next_word (next_w[i]),
         .live      (live[i]),
         .word      (words[i]),
         .match     (match[i])
      );
   end

   // pick the back entry through its one-hot last flag
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (last[i]) begin
            tail_word = tail_word | words[i];
         end
      end
   end

   // next fill count
   always_comb begin
      count_in = count_ff;
      if (push_front_ok || push_back_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_front_ok || pop_back_ok) begin
         count_in = count_ff - CNT_W'(1);
      end else if (req_fire && do_clear) begin
         count_in = '0;
      end
   end

   // capture the outcome of the accepted word
   always_comb begin
      stage_in.status  = ST_OK;
      stage_in.data    = '0;
      stage_in.is_find = do_find;
      stage_in.match   = match;
      stage_in.count   = count_in;
      if ((req_mode == MODE_PUSH_FRONT || req_mode == MODE_PUSH_BACK) && full) begin
         stage_in.status = ST_FULL;
      end
      if ((req_mode == MODE_POP_FRONT || req_mode == MODE_POP_BACK) && empty) begin
         stage_in.status = ST_EMPTY;
      end
      if (pop_front_ok) begin
         stage_in.data = word_to_out(words[0]);
      end else if (pop_back_ok) begin
         stage_in.data = word_to_out(tail_word);
      end
   end

   // hold the staged outcome until the response register takes it
   assign req_ready = !stage_valid_ff || stage_take;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (stage_take) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= stage_in;
      end
   end

   deq_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid_ff),
      .stage         (stage_ff),
      .stage_take    (stage_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_front_ok || push_back_ok) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop_front_ok || pop_back_ok) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("removal did not shrink the queue");

   a_stage_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> stage_ff.count == count_ff)
      else $error("staged count differs from fill count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_count == '0)))
      else $error("empty flag disagrees with count");
`endif

endmodule
